// ----- rtl/tilemap_box_collision_resolve_core_macros.svh -----
// Assertion macros for the tile-map box collision resolver.
// Each use names a label, an antecedent and a consequent, sampled on clk and
// disabled while rst is high.
`ifndef TILEMAP_BOX_COLLISION_RESOLVE_CORE_MACROS_SVH
`define TILEMAP_BOX_COLLISION_RESOLVE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TBCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbcr: same-cycle check failed");
`define TBCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbcr: next-cycle check failed");
`else
`define TBCR_ASSERT_NOW(label, ante, cons)
`define TBCR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/tbcr_pkg.sv -----
package tbcr_pkg;

  // Field widths of the item and result channels.
  localparam int POS_W   = 16;
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 11;
  localparam int DELTA_W = 12;
  localparam int MASK_W  = 8;
  localparam int TILE_W  = 8;

  // Item kinds.
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_MOVE = 1'b1;

  // Register reset value.
  localparam logic [MASK_W-1:0] LAYER_RESET = 8'd1;

  // Preset block of tiles loaded by the clearing pass.
  localparam int PRESET_LO = 8;
  localparam int PRESET_HI = 9;
  localparam logic [TILE_W-1:0] PRESET_VALUE = 8'd1;

endpackage

// ----- rtl/tbcr_cfg_if.sv -----
interface tbcr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tbcr_pkg::MASK_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tbcr_item_if.sv -----
interface tbcr_item_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [tbcr_pkg::COORD_W-1:0] tile_col;
  logic signed [tbcr_pkg::COORD_W-1:0] tile_row;
  logic [tbcr_pkg::TILE_W-1:0]         tile_value;
  logic signed [tbcr_pkg::POS_W-1:0]   pos_x;
  logic signed [tbcr_pkg::POS_W-1:0]   pos_y;
  logic [tbcr_pkg::SIZE_W-1:0]         size_w;
  logic [tbcr_pkg::SIZE_W-1:0]         size_h;
  logic signed [tbcr_pkg::DELTA_W-1:0] delta_x;
  logic signed [tbcr_pkg::DELTA_W-1:0] delta_y;
  logic [tbcr_pkg::MASK_W-1:0]         solid_mask;
  logic [tbcr_pkg::MASK_W-1:0]         sense_mask;

  modport source (
    output valid, output kind, output tile_col, output tile_row, output tile_value,
    output pos_x, output pos_y, output size_w, output size_h,
    output delta_x, output delta_y, output solid_mask, output sense_mask,
    input ready
  );
  modport sink (
    input valid, input kind, input tile_col, input tile_row, input tile_value,
    input pos_x, input pos_y, input size_w, input size_h,
    input delta_x, input delta_y, input solid_mask, input sense_mask,
    output ready
  );
endinterface

// ----- rtl/tbcr_result_if.sv -----
interface tbcr_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [tbcr_pkg::POS_W-1:0] new_pos_x;
  logic signed [tbcr_pkg::POS_W-1:0] new_pos_y;
  logic                              hit_solid;
  logic                              hit_trigger;
  logic                              write_ok;

  modport source (
    output valid, output new_pos_x, output new_pos_y, output hit_solid,
    output hit_trigger, output write_ok, input ready
  );
  modport sink (
    input valid, input new_pos_x, input new_pos_y, input hit_solid,
    input hit_trigger, input write_ok, output ready
  );
endinterface

// ----- rtl/tbcr_ram.sv -----
module tbcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tilemap_box_collision_resolve_core.sv -----
// Tile-map box collision resolver.
// Channels: cmd takes one item per handshake (valid and ready both high):
// a set item writes one tile of the map, a move item moves a box along X and
// then Y against the map. result returns exactly one item per cmd item.
// cfg writes the collision layer register; it is always ready and is meant
// to be written only while the block is idle.
// A move item takes longer the more tiles its box covers on each axis; a hit
// ends a scan early, and a box whose masks match no layer skips the scan. The
// scan reads the tile RAM once per cycle and limits a move item. The block
// works on one item at a time and takes the next one the cycle after it
// loads a result.
// Reset: rst clears control state and the collision layer goes to 1. Then a
// clearing pass over all MAP_COLS * MAP_ROWS tiles (4096 by default) writes the
// tile RAM with zeros and the four preset tiles; cmd is not ready until it
// ends, while cfg writes are taken.
// Stall: a result waits in an output register while the receiver holds
// ready low; the next item is accepted meanwhile, and it finishes only once
// the register has been emptied.
`include "tilemap_box_collision_resolve_core_macros.svh"

module tilemap_box_collision_resolve_core #(
  parameter int MAP_COLS       = 64,
  parameter int MAP_ROWS       = 64,
  parameter int TILE_SHIFT     = 4,
  parameter int FRAC_BITS      = 4,
  parameter int MAX_SPAN_TILES = 4
) (
  input  logic          clk,
  input  logic          rst,
  tbcr_cfg_if.sink      cfg,
  tbcr_item_if.sink     cmd,
  tbcr_result_if.source result
);

  localparam int TS_BITS = TILE_SHIFT + FRAC_BITS;
  localparam int DEPTH   = MAP_COLS * MAP_ROWS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Wide enough for a position plus a size plus one tile minus one.
  localparam int SW      = 20;
  localparam int CNT_W   = 11;
  localparam int POS_W   = tbcr_pkg::POS_W;
  localparam int SIZE_W  = tbcr_pkg::SIZE_W;
  localparam int DELTA_W = tbcr_pkg::DELTA_W;
  localparam int COORD_W = tbcr_pkg::COORD_W;
  localparam logic signed [SW-1:0] TILE_M1 = SW'((1 << TS_BITS) - 1);
  localparam logic signed [SW-1:0] SPAN    = SW'(MAX_SPAN_TILES + 1);
  localparam logic signed [SW-1:0] COLS_S  = SW'(MAP_COLS);
  localparam logic signed [SW-1:0] ROWS_S  = SW'(MAP_ROWS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SET, S_STEP, S_SETUP, S_SCAN, S_OUT
  } state_t;

  state_t state;

  // Register and captured item.
  logic [tbcr_pkg::MASK_W-1:0] layer;
  logic                        is_move;
  logic signed [COORD_W-1:0]   tcol, trow;
  logic [tbcr_pkg::TILE_W-1:0] tval;
  logic signed [POS_W-1:0]     px, py;
  logic [SIZE_W-1:0]           bw, bh;
  logic signed [DELTA_W-1:0]   dx, dy;
  logic                        solid, active, found, axis_y, write_ok_q;

  // Scan counters.
  logic signed [SW-1:0] c_cur, c_hi, r_cur, r_lo, r_hi;
  logic                 rd_pend;

  // Clearing pass counters.
  logic [CNT_W-1:0] clr_col, clr_row;
  logic [AW-1:0]    clr_addr;

  // Output register.
  logic                    res_valid;
  logic signed [POS_W-1:0] res_x, res_y;
  logic                    res_solid, res_trigger, res_ok;

  // Tile RAM ports.
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr, mem_raddr, set_addr;
  logic [tbcr_pkg::TILE_W-1:0] mem_wdata, mem_rdata, clr_data;

  function automatic logic in_map(input logic signed [SW-1:0] c,
                                  input logic signed [SW-1:0] r);
    in_map = (c >= 0) && (r >= 0) && (c < COLS_S) && (r < ROWS_S);
  endfunction

  function automatic logic [AW-1:0] tile_addr(input logic signed [SW-1:0] c,
                                              input logic signed [SW-1:0] r);
    tile_addr = AW'(AW'(r) * AW'(MAP_COLS) + AW'(c));
  endfunction

  // Set item coordinate.
  logic signed [SW-1:0] tc_ext, tr_ext;
  logic                 set_in_map;

  always_comb begin
    tc_ext     = $signed({{(SW-COORD_W){tcol[COORD_W-1]}}, tcol});
    tr_ext     = $signed({{(SW-COORD_W){trow[COORD_W-1]}}, trow});
    set_in_map = in_map(tc_ext, tr_ext);
    set_addr   = tile_addr(tc_ext, tr_ext);
  end

  // Covered tile range of the box at its current position.
  logic signed [SW-1:0] x_ext, y_ext, w_ext, h_ext;
  logic signed [SW-1:0] c0, c1_raw, c1, r0, r1_raw, r1;

  always_comb begin
    x_ext  = $signed({{(SW-POS_W){px[POS_W-1]}}, px});
    y_ext  = $signed({{(SW-POS_W){py[POS_W-1]}}, py});
    w_ext  = $signed({{(SW-SIZE_W){1'b0}}, bw});
    h_ext  = $signed({{(SW-SIZE_W){1'b0}}, bh});
    c0     = x_ext >>> TS_BITS;
    r0     = y_ext >>> TS_BITS;
    c1_raw = (x_ext + w_ext + TILE_M1) >>> TS_BITS;
    r1_raw = (y_ext + h_ext + TILE_M1) >>> TS_BITS;
    c1     = (c1_raw > c0 + SPAN) ? c0 + SPAN : c1_raw;
    r1     = (r1_raw > r0 + SPAN) ? r0 + SPAN : r1_raw;
  end

  // Movement by the delta of the current axis, wrapping to 16 bits.
  logic signed [POS_W-1:0] px_step, py_step;

  always_comb begin
    px_step = px + {{(POS_W-DELTA_W){dx[DELTA_W-1]}}, dx};
    py_step = py + {{(POS_W-DELTA_W){dy[DELTA_W-1]}}, dy};
  end

  // Snap of the current axis to the tile grid.
  logic signed [SW-1:0]    p_ext, s_ext, snap_far, snap_near;
  logic                    d_pos;
  logic signed [POS_W-1:0] snap_val;

  always_comb begin
    p_ext     = axis_y ? y_ext : x_ext;
    s_ext     = axis_y ? h_ext : w_ext;
    d_pos     = axis_y ? (!dy[DELTA_W-1] && (dy != '0)) : (!dx[DELTA_W-1] && (dx != '0));
    snap_far  = ((p_ext + s_ext) & ~TILE_M1) - s_ext;
    snap_near = (p_ext + TILE_M1) & ~TILE_M1;
    snap_val  = d_pos ? snap_far[POS_W-1:0] : snap_near[POS_W-1:0];
  end

  // Scan step: an out-of-map tile or a nonzero tile read back is a hit.
  logic issue, hit_now, scan_end, r_wrap;

  always_comb begin
    issue     = (c_cur < c_hi) && (r_lo < r_hi);
    hit_now   = (issue && !in_map(c_cur, r_cur)) || (rd_pend && (mem_rdata != '0));
    scan_end  = hit_now || (!issue && !rd_pend);
    r_wrap    = (r_cur + SW'(1) >= r_hi);
    mem_raddr = tile_addr(c_cur, r_cur);
  end

  // Tile RAM write side: clearing pass or set item.
  always_comb begin
    clr_data = '0;
    if ((clr_col == CNT_W'(tbcr_pkg::PRESET_LO) || clr_col == CNT_W'(tbcr_pkg::PRESET_HI)) &&
        (clr_row == CNT_W'(tbcr_pkg::PRESET_LO) || clr_row == CNT_W'(tbcr_pkg::PRESET_HI))) begin
      clr_data = tbcr_pkg::PRESET_VALUE;
    end
    mem_we    = (state == S_CLEAR) || ((state == S_SET) && set_in_map);
    mem_waddr = (state == S_CLEAR) ? clr_addr : set_addr;
    mem_wdata = (state == S_CLEAR) ? clr_data : tval;
  end

  tbcr_ram #(
    .WIDTH (tbcr_pkg::TILE_W),
    .DEPTH (DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshakes.
  assign cfg.ready          = 1'b1;
  assign cmd.ready          = (state == S_IDLE);
  assign result.valid       = res_valid;
  assign result.new_pos_x   = res_x;
  assign result.new_pos_y   = res_y;
  assign result.hit_solid   = res_solid;
  assign result.hit_trigger = res_trigger;
  assign result.write_ok    = res_ok;

  // Sequencer, registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_col   <= '0;
      clr_row   <= '0;
      clr_addr  <= '0;
      layer     <= tbcr_pkg::LAYER_RESET;
      res_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        layer <= cfg.data;
      end
      // In S_OUT the output register is refilled instead of emptied.
      if (res_valid && result.ready && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_col == CNT_W'(MAP_COLS - 1)) begin
            clr_col <= '0;
            clr_row <= clr_row + CNT_W'(1);
          end else begin
            clr_col <= clr_col + CNT_W'(1);
          end
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (cmd.valid) begin
            is_move <= (cmd.kind == tbcr_pkg::KIND_MOVE);
            tcol    <= cmd.tile_col;
            trow    <= cmd.tile_row;
            tval    <= cmd.tile_value;
            px      <= cmd.pos_x;
            py      <= cmd.pos_y;
            bw      <= cmd.size_w;
            bh      <= cmd.size_h;
            dx      <= cmd.delta_x;
            dy      <= cmd.delta_y;
            solid   <= (cmd.solid_mask & layer) != '0;
            active  <= ((cmd.solid_mask | cmd.sense_mask) & layer) != '0;
            found   <= 1'b0;
            axis_y  <= 1'b0;
            state   <= (cmd.kind == tbcr_pkg::KIND_MOVE) ? S_STEP : S_SET;
          end
        end

        S_SET: begin
          write_ok_q <= set_in_map;
          state      <= S_OUT;
        end

        S_STEP: begin
          if (axis_y) begin
            py <= py_step;
          end else begin
            px <= px_step;
          end
          if (active) begin
            state <= S_SETUP;
          end else if (axis_y) begin
            state <= S_OUT;
          end else begin
            axis_y <= 1'b1;
          end
        end

        S_SETUP: begin
          c_cur   <= c0;
          c_hi    <= c1;
          r_cur   <= r0;
          r_lo    <= r0;
          r_hi    <= r1;
          rd_pend <= 1'b0;
          state   <= S_SCAN;
        end

        S_SCAN: begin
          if (scan_end) begin
            rd_pend <= 1'b0;
            if (hit_now) begin
              found <= 1'b1;
              if (solid) begin
                if (axis_y) begin
                  py <= snap_val;
                end else begin
                  px <= snap_val;
                end
              end
            end
            if (axis_y) begin
              state <= S_OUT;
            end else begin
              axis_y <= 1'b1;
              state  <= S_STEP;
            end
          end else begin
            rd_pend <= issue;
            if (issue) begin
              if (r_wrap) begin
                r_cur <= r_lo;
                c_cur <= c_cur + SW'(1);
              end else begin
                r_cur <= r_cur + SW'(1);
              end
            end
          end
        end

        S_OUT: begin
          if (!res_valid || result.ready) begin
            res_valid   <= 1'b1;
            res_x       <= is_move ? px : '0;
            res_y       <= is_move ? py : '0;
            res_solid   <= is_move && found && solid;
            res_trigger <= is_move && found && !solid;
            res_ok      <= !is_move && write_ok_q;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and the result register.
  `TBCR_ASSERT_NEXT(a_one_item_at_a_time, cmd.valid && cmd.ready, !cmd.ready)
  `TBCR_ASSERT_NOW(a_read_only_in_scan, rd_pend, state == S_SCAN)
  `TBCR_ASSERT_NOW(a_hit_flags_exclusive, result.valid, !(result.hit_solid && result.hit_trigger))
  `TBCR_ASSERT_NOW(a_set_has_no_hit, result.valid && result.write_ok,
                   !result.hit_solid && !result.hit_trigger)

endmodule
